// ===== rtl/bhpq_pkg.sv =====
// Shared types, codes and the heap order compare for the binary heap queue.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bhpq_pkg;

  // Operation codes carried in the input kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic               found;
    logic [6:0]         occupancy;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_READ,
    ST_UP_CMP,
    ST_RM_LOAD,
    ST_DN_READ,
    ST_DN_CMP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Read address selection for the two memory read ports
  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_GRAND,
    RD_ENDS,
    RD_CHILDREN,
    RD_GRANDKIDS,
    RD_SCAN
  } rd_sel_t;

  // Source of the word written at the current position
  typedef enum logic [1:0] {
    WR_HOLD,
    WR_PARENT,
    WR_CHILD
  } wr_src_t;

  // Position register update
  typedef enum logic [1:0] {
    POS_KEEP,
    POS_UP,
    POS_DOWN
  } pos_op_t;

  typedef struct packed {
    logic       start_ins;
    logic       start_srch;
    logic       load_ends;
    logic       clr_top;
    logic       res_set;
    logic [1:0] res_status;
    logic       set_found;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_src_t    wr_src;
    pos_op_t    pos_op;
    logic       scan_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_is_root;
    logic parent_is_root;
    logic up_move;
    logic dn_has_left;
    logic dn_move;
    logic child_has_kids;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } sts_t;

  // True when a belongs nearer the root than b under the selected order
  function automatic logic ranks_before(input logic mode,
                                        input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

endpackage

// ===== rtl/bhpq_datapath.sv =====
// Datapath of the heap queue: heap memory, entry count, sift position,
// carried element, search scan and output register. Uses bhpq_pkg.
`timescale 1ns / 1ps

module bhpq_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  bhpq_pkg::in_item_t  in_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  bhpq_pkg::cmd_t      cmd,
  output bhpq_pkg::sts_t      sts,
  input  logic                out_ready,
  output logic                out_valid,
  output bhpq_pkg::out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = CW + 1;

  logic [31:0]        mem [CAPACITY];
  logic               mode;
  logic [CW-1:0]      cnt;
  logic [AW-1:0]      pos;
  logic signed [31:0] hold;
  logic signed [31:0] top;
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;
  logic [1:0]         status_r;
  logic               found_r;
  logic [W-1:0]       scan_idx;
  logic               scan_v0;
  logic               scan_v1;

  logic [W-1:0]       n_w;
  logic [W-1:0]       pos_w;
  logic [W-1:0]       parent_w;
  logic [W-1:0]       grand_w;
  logic [W-1:0]       left_w;
  logic [W-1:0]       right_w;
  logic [W-1:0]       rclip_w;
  logic               child_left;
  logic [W-1:0]       cidx_w;
  logic signed [31:0] cdata;
  logic [W-1:0]       cleft_w;
  logic [W-1:0]       cright_w;
  logic [W-1:0]       crclip_w;
  logic [W-1:0]       ra_w;
  logic [W-1:0]       rb_w;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      rb;
  logic [31:0]        wd;
  logic [CW+6:0]      occ_ext;

  // Index arithmetic around the current position
  always_comb begin
    n_w      = {1'b0, cnt};
    pos_w    = {{(W-AW){1'b0}}, pos};
    parent_w = (pos_w - W'(1)) >> 1;
    grand_w  = (parent_w - W'(1)) >> 1;
    left_w   = {pos_w[W-2:0], 1'b0} + W'(1);
    right_w  = left_w + W'(1);
    rclip_w  = (right_w >= n_w) ? left_w : right_w;
    // Right child wins ties
    child_left = bhpq_pkg::ranks_before(mode, rd_a, rd_b);
    cidx_w   = child_left ? left_w : rclip_w;
    cdata    = child_left ? rd_a : rd_b;
    cleft_w  = {cidx_w[W-2:0], 1'b0} + W'(1);
    cright_w = cleft_w + W'(1);
    crclip_w = (cright_w >= n_w) ? cleft_w : cright_w;
  end

  // Status back to the controller
  always_comb begin
    sts.full           = (n_w == W'(CAPACITY));
    sts.empty          = (cnt == '0);
    sts.pos_is_root    = (pos == '0);
    sts.parent_is_root = (parent_w == '0);
    sts.up_move        = bhpq_pkg::ranks_before(mode, hold, rd_a);
    sts.dn_has_left    = (left_w < n_w);
    sts.dn_move        = bhpq_pkg::ranks_before(mode, cdata, hold);
    sts.child_has_kids = (cleft_w < n_w);
    sts.scan_hit       = (scan_v0 && (rd_a == hold)) || (scan_v1 && (rd_b == hold));
    sts.scan_end       = (scan_idx >= n_w) && !scan_v0 && !scan_v1;
    sts.out_free       = !out_valid || out_ready;
  end

  // Select read addresses
  always_comb begin
    ra_w = '0;
    rb_w = '0;
    case (cmd.rd_sel)
      bhpq_pkg::RD_PARENT:    ra_w = parent_w;
      bhpq_pkg::RD_GRAND:     ra_w = grand_w;
      bhpq_pkg::RD_ENDS: begin
        ra_w = '0;
        rb_w = n_w - W'(1);
      end
      bhpq_pkg::RD_CHILDREN: begin
        ra_w = left_w;
        rb_w = rclip_w;
      end
      bhpq_pkg::RD_GRANDKIDS: begin
        ra_w = cleft_w;
        rb_w = crclip_w;
      end
      bhpq_pkg::RD_SCAN: begin
        ra_w = scan_idx;
        rb_w = scan_idx + W'(1);
      end
      default: begin
        ra_w = '0;
        rb_w = '0;
      end
    endcase
    ra = ra_w[AW-1:0];
    rb = rb_w[AW-1:0];
  end

  // Select write data
  always_comb begin
    case (cmd.wr_src)
      bhpq_pkg::WR_PARENT: wd = rd_a;
      bhpq_pkg::WR_CHILD:  wd = cdata;
      default:             wd = hold;
    endcase
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[pos] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      cnt       <= '0;
      scan_v0   <= 1'b0;
      scan_v1   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      if (cmd.start_ins) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.load_ends) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.start_srch) begin
        scan_v0 <= 1'b0;
        scan_v1 <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_v0 <= (scan_idx < n_w);
        scan_v1 <= ((scan_idx + W'(1)) < n_w);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign occ_ext = {7'b0, cnt};

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_ins || cmd.start_srch) begin
      hold <= in_data.value;
    end else if (cmd.load_ends) begin
      hold <= rd_b;
    end

    if (cmd.start_ins) begin
      pos <= cnt[AW-1:0];
    end else if (cmd.load_ends) begin
      pos <= '0;
    end else begin
      case (cmd.pos_op)
        bhpq_pkg::POS_UP:   pos <= parent_w[AW-1:0];
        bhpq_pkg::POS_DOWN: pos <= cidx_w[AW-1:0];
        default:            pos <= pos;
      endcase
    end

    if (cmd.clr_top) begin
      top <= '0;
    end else if (cmd.load_ends) begin
      top <= rd_a;
    end

    if (cmd.res_set) begin
      status_r <= cmd.res_status;
      found_r  <= 1'b0;
    end else if (cmd.set_found) begin
      found_r <= 1'b1;
    end

    if (cmd.start_srch) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + W'(2);
    end

    if (cmd.out_load) begin
      out_data.status    <= status_r;
      out_data.top_value <= top;
      out_data.found     <= found_r;
      out_data.occupancy <= occ_ext[6:0];
    end
  end

endmodule

// ===== rtl/bhpq_ctrl.sv =====
// Controller of the heap queue: state machine that sequences insert,
// remove and search over the datapath. Uses bhpq_pkg.
`timescale 1ns / 1ps

module bhpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_kind,
  output logic           in_ready,
  input  bhpq_pkg::sts_t sts,
  output bhpq_pkg::cmd_t cmd
);

  bhpq_pkg::state_t state;
  bhpq_pkg::state_t state_next;
  logic             accept;

  assign in_ready = (state == bhpq_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bhpq_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            bhpq_pkg::KIND_INSERT:
              state_next = sts.full ? bhpq_pkg::ST_FINISH : bhpq_pkg::ST_UP_READ;
            bhpq_pkg::KIND_REMOVE:
              state_next = sts.empty ? bhpq_pkg::ST_FINISH : bhpq_pkg::ST_RM_LOAD;
            bhpq_pkg::KIND_SEARCH:
              state_next = bhpq_pkg::ST_SCAN;
            default:
              state_next = bhpq_pkg::ST_FINISH;
          endcase
        end
      end
      bhpq_pkg::ST_UP_READ:
        state_next = sts.pos_is_root ? bhpq_pkg::ST_FINISH : bhpq_pkg::ST_UP_CMP;
      bhpq_pkg::ST_UP_CMP: begin
        if (!sts.up_move) begin
          state_next = bhpq_pkg::ST_FINISH;
        end else if (sts.parent_is_root) begin
          state_next = bhpq_pkg::ST_UP_READ;
        end
      end
      bhpq_pkg::ST_RM_LOAD:
        state_next = bhpq_pkg::ST_DN_READ;
      bhpq_pkg::ST_DN_READ:
        state_next = sts.dn_has_left ? bhpq_pkg::ST_DN_CMP : bhpq_pkg::ST_FINISH;
      bhpq_pkg::ST_DN_CMP: begin
        if (!sts.dn_move) begin
          state_next = bhpq_pkg::ST_FINISH;
        end else if (!sts.child_has_kids) begin
          state_next = bhpq_pkg::ST_DN_READ;
        end
      end
      bhpq_pkg::ST_SCAN: begin
        if (sts.scan_hit || sts.scan_end) begin
          state_next = bhpq_pkg::ST_FINISH;
        end
      end
      bhpq_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          state_next = bhpq_pkg::ST_IDLE;
        end
      end
      default:
        state_next = bhpq_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = bhpq_pkg::RD_NONE;
    cmd.wr_src     = bhpq_pkg::WR_HOLD;
    cmd.pos_op     = bhpq_pkg::POS_KEEP;
    cmd.res_status = bhpq_pkg::STATUS_OK;
    case (state)
      bhpq_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.clr_top = 1'b1;
          cmd.res_set = 1'b1;
          case (in_kind)
            bhpq_pkg::KIND_INSERT: begin
              if (sts.full) begin
                cmd.res_status = bhpq_pkg::STATUS_FULL;
              end else begin
                cmd.start_ins = 1'b1;
              end
            end
            bhpq_pkg::KIND_REMOVE: begin
              if (sts.empty) begin
                cmd.res_status = bhpq_pkg::STATUS_EMPTY;
              end else begin
                cmd.rd_sel = bhpq_pkg::RD_ENDS;
              end
            end
            bhpq_pkg::KIND_SEARCH:
              cmd.start_srch = 1'b1;
            default:
              cmd.res_status = bhpq_pkg::STATUS_OK;
          endcase
        end
      end
      bhpq_pkg::ST_UP_READ: begin
        if (sts.pos_is_root) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_sel = bhpq_pkg::RD_PARENT;
        end
      end
      bhpq_pkg::ST_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.up_move) begin
          // Drop the parent into the hole and climb
          cmd.wr_src = bhpq_pkg::WR_PARENT;
          cmd.pos_op = bhpq_pkg::POS_UP;
          if (!sts.parent_is_root) begin
            cmd.rd_sel = bhpq_pkg::RD_GRAND;
          end
        end
      end
      bhpq_pkg::ST_RM_LOAD:
        cmd.load_ends = 1'b1;
      bhpq_pkg::ST_DN_READ: begin
        if (sts.dn_has_left) begin
          cmd.rd_sel = bhpq_pkg::RD_CHILDREN;
        end else begin
          cmd.wr_en = 1'b1;
        end
      end
      bhpq_pkg::ST_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.dn_move) begin
          // Lift the better child into the hole and descend
          cmd.wr_src = bhpq_pkg::WR_CHILD;
          cmd.pos_op = bhpq_pkg::POS_DOWN;
          if (sts.child_has_kids) begin
            cmd.rd_sel = bhpq_pkg::RD_GRANDKIDS;
          end
        end
      end
      bhpq_pkg::ST_SCAN: begin
        cmd.rd_sel    = bhpq_pkg::RD_SCAN;
        cmd.scan_step = 1'b1;
        cmd.set_found = sts.scan_hit;
      end
      bhpq_pkg::ST_FINISH:
        cmd.out_load = sts.out_free;
      default:
        cmd.rd_sel = bhpq_pkg::RD_NONE;
    endcase
  end

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: controller plus datapath.
// Depends on bhpq_pkg, bhpq_ctrl and bhpq_datapath.
`timescale 1ns / 1ps

// Array-based binary heap of signed 32-bit priorities, min or max order set by
// cfg_wr_data (write cfg_wr_en/cfg_wr_data only while idle). One item at a time
// is processed; the next item is taken while the previous result waits in the
// output register. A search ends at the first match. Sifting moves one level
// per cycle, set by the heap memory's two registered read ports and one write
// port; search checks two entries per cycle through the same ports. The store
// needs no clearing after reset.

module binary_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bhpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bhpq_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  bhpq_pkg::cmd_t cmd;
  bhpq_pkg::sts_t sts;

  bhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bhpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/bhpq_checker.sv =====
// Port-level checks on result consistency of the heap queue, bound to the top.
// Depends on bhpq_pkg and binary_heap_priority_queue.
`timescale 1ns / 1ps

module bhpq_checker #(
  parameter int CAPACITY = 64
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input bhpq_pkg::out_item_t out_data
);

  localparam logic [6:0] CAP_OCC = 7'(CAPACITY);

  // A refused insert means the heap is full
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == bhpq_pkg::STATUS_FULL) |->
      out_data.occupancy == CAP_OCC)
    else $error("full status without full occupancy");

  // A refused remove means the heap is empty
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == bhpq_pkg::STATUS_EMPTY) |->
      out_data.occupancy == 7'd0)
    else $error("empty status with nonzero occupancy");

  // A nonzero top value only comes from a successful remove
  a_top_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.top_value != 32'sd0) |->
      (out_data.status == bhpq_pkg::STATUS_OK) && !out_data.found)
    else $error("top value on a result that is not a remove");

  // A hit only comes from a search
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |->
      (out_data.status == bhpq_pkg::STATUS_OK) && (out_data.top_value == 32'sd0))
    else $error("found flag on a result that is not a search");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind binary_heap_priority_queue bhpq_checker #(
  .CAPACITY (CAPACITY)
) u_bhpq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
